// ===== sv/colour_blob_best_match_core_macros.svh =====
// Assertion macros for the colour blob best-match core.
// Included by files that assert; expects clk and rst_n in scope.
`ifndef COLOUR_BLOB_BEST_MATCH_CORE_MACROS_SVH
`define COLOUR_BLOB_BEST_MATCH_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CBBM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbbm same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CBBM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbbm next-cycle check failed");

`endif

// ===== sv/cbbm_pkg.sv =====
// Package for the colour blob best-match core: item types, target codes,
// hue constants and the Q0.15 cosine table. No dependencies.
`default_nettype none

package cbbm_pkg;

  typedef struct packed {
    logic [8:0]  hue_deg;
    logic [7:0]  saturation;
    logic [19:0] pixel_count;
    logic [7:0]  red_mean;
    logic [7:0]  green_mean;
    logic [7:0]  blue_mean;
    logic        last_blob;
  } cbbm_in_t;

  typedef struct packed {
    logic       found;
    logic [7:0] best_index;
  } cbbm_out_t;

  typedef struct packed {
    logic active;
    logic qualify;
    logic last;
  } cbbm_ctl_t;

  localparam logic [1:0] TGT_RED    = 2'd0;
  localparam logic [1:0] TGT_BLUE   = 2'd1;
  localparam logic [1:0] TGT_YELLOW = 2'd2;

  localparam logic [8:0] HUE_RED    = 9'd0;
  localparam logic [8:0] HUE_BLUE   = 9'd240;
  localparam logic [8:0] HUE_YELLOW = 9'd60;
  localparam logic [8:0] HUE_WRAP   = 9'd360;
  localparam logic [8:0] HUE_HALF   = 9'd180;
  localparam logic [8:0] COS_SPAN   = 9'd50;

  localparam int COS_BITS   = 15;
  localparam int SAT2_BITS  = 16;
  localparam int SCORE_FRAC = 31;

  localparam logic [14:0] MIN_COS = 15'd21299;

  function automatic logic [14:0] cos_q15(input logic [5:0] ang);
    logic [14:0] c;
    case (ang)
      6'd0:  c = 15'd32767;  6'd1:  c = 15'd32763;  6'd2:  c = 15'd32748;
      6'd3:  c = 15'd32723;  6'd4:  c = 15'd32688;  6'd5:  c = 15'd32643;
      6'd6:  c = 15'd32588;  6'd7:  c = 15'd32524;  6'd8:  c = 15'd32449;
      6'd9:  c = 15'd32365;  6'd10: c = 15'd32270;  6'd11: c = 15'd32166;
      6'd12: c = 15'd32052;  6'd13: c = 15'd31928;  6'd14: c = 15'd31795;
      6'd15: c = 15'd31651;  6'd16: c = 15'd31499;  6'd17: c = 15'd31336;
      6'd18: c = 15'd31164;  6'd19: c = 15'd30983;  6'd20: c = 15'd30792;
      6'd21: c = 15'd30592;  6'd22: c = 15'd30382;  6'd23: c = 15'd30163;
      6'd24: c = 15'd29935;  6'd25: c = 15'd29698;  6'd26: c = 15'd29452;
      6'd27: c = 15'd29197;  6'd28: c = 15'd28932;  6'd29: c = 15'd28660;
      6'd30: c = 15'd28378;  6'd31: c = 15'd28088;  6'd32: c = 15'd27789;
      6'd33: c = 15'd27482;  6'd34: c = 15'd27166;  6'd35: c = 15'd26842;
      6'd36: c = 15'd26510;  6'd37: c = 15'd26170;  6'd38: c = 15'd25822;
      6'd39: c = 15'd25466;  6'd40: c = 15'd25102;  6'd41: c = 15'd24730;
      6'd42: c = 15'd24351;  6'd43: c = 15'd23965;  6'd44: c = 15'd23571;
      6'd45: c = 15'd23170;  6'd46: c = 15'd22763;  6'd47: c = 15'd22348;
      6'd48: c = 15'd21926;  6'd49: c = 15'd21498;
      default: c = 15'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/colour_blob_best_match_core.sv =====
// Top level of the colour blob best-match core: front end, blob queue,
// back end and result register. Uses cbbm_pkg and the assertion macros.
// Blobs of a frame are pushed on in_push/in_full; the last one carries
// last_blob. Each frame yields one item on out_empty/out_pop: found and
// best_index. The target hue is written on cfg_valid/cfg_ready (always ready).
// The front end takes one blob per cycle while the queue is not full, into a
// queue of QUEUE_DEPTH entries. The back end's sequencer steps each blob
// through pop, two multiply steps and compare, plus a result step on a frame's
// last blob, and pops the next blob only once it is through with the last.
// Reset clears the queue, the frame state and the result register, and sets
// the target to red. While the result waits for out_pop the front end keeps
// filling the queue; the back end holds the next result until the register
// frees, and in_full rises once the queue fills.
`default_nettype none
`include "colour_blob_best_match_core_macros.svh"

module colour_blob_best_match_core #(
  parameter int MAX_BLOBS   = 256,
  parameter int SIZE_BITS   = 20,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire cbbm_pkg::cbbm_in_t  in_item,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output cbbm_pkg::cbbm_out_t      out_item,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_data
);
  import cbbm_pkg::*;

  localparam int IW = $clog2(MAX_BLOBS);
  localparam int EW = $bits(cbbm_ctl_t) + COS_BITS + SAT2_BITS + SIZE_BITS + IW;

  cbbm_ctl_t            f_ctl, b_ctl;
  logic [14:0]          f_cos, b_cos;
  logic [15:0]          f_sat2, b_sat2;
  logic [SIZE_BITS-1:0] f_size, b_size;
  logic [IW-1:0]        f_idx, b_idx;
  logic [EW-1:0]        q_wdata, q_rdata;
  logic                 q_push, q_pop, q_full, q_empty;
  logic                 res_valid, res_ready;
  cbbm_out_t            res_item;
  logic                 out_valid_r;
  cbbm_out_t            out_item_r;

  cbbm_front #(
    .MAX_BLOBS (MAX_BLOBS),
    .SIZE_BITS (SIZE_BITS),
    .IW        (IW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_ctl     (f_ctl),
    .q_cos     (f_cos),
    .q_sat2    (f_sat2),
    .q_size    (f_size),
    .q_idx     (f_idx)
  );

  assign q_wdata = {f_ctl, f_cos, f_sat2, f_size, f_idx};
  assign {b_ctl, b_cos, b_sat2, b_size, b_idx} = q_rdata;

  cbbm_queue #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  cbbm_back #(
    .SIZE_BITS (SIZE_BITS),
    .IW        (IW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_ctl     (b_ctl),
    .q_cos     (b_cos),
    .q_sat2    (b_sat2),
    .q_size    (b_size),
    .q_idx     (b_idx),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  assign res_ready = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_item_r <= res_item;
    end
  end

  `CBBM_ASSERT_IMP(a_pop_not_empty, q_pop, !q_empty)
  `CBBM_ASSERT_NXT(a_pop_frees_slot, q_pop, !in_full)
  `CBBM_ASSERT_IMP(a_result_slot_free, res_valid && res_ready, out_empty || out_pop)
  `CBBM_ASSERT_IMP(a_index_zero, !out_empty && !out_item.found, out_item.best_index == 8'd0)

endmodule

`default_nettype wire

// ===== sv/cbbm_front.sv =====
// Front end: accepts blobs, holds the target register and the blob counter,
// classifies each blob and pushes it to the queue. Uses cbbm_pkg.
`default_nettype none

module cbbm_front #(
  parameter int MAX_BLOBS = 256,
  parameter int SIZE_BITS = 20,
  parameter int IW        = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire cbbm_pkg::cbbm_in_t  in_item,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_data,
  input  wire logic                q_full,
  output logic                     q_push,
  output cbbm_pkg::cbbm_ctl_t      q_ctl,
  output logic [14:0]              q_cos,
  output logic [15:0]              q_sat2,
  output logic [SIZE_BITS-1:0]     q_size,
  output logic [IW-1:0]            q_idx
);
  import cbbm_pkg::*;

  localparam int CW = $clog2(MAX_BLOBS + 1);
  localparam logic [9:0] WRAP10 = 10'(HUE_WRAP);

  function automatic logic pair_close(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] ad;
    logic [9:0] d4;
    ad = (x > y) ? x - y : y - x;
    d4 = {ad, 2'b00};
    return (d4 < {2'b00, x}) && (d4 < {2'b00, y});
  endfunction

  logic [1:0]    target_colour_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [8:0]    hue_w, tgt, hue_dist, ang;
  logic [9:0]    diff;
  logic          tgt_ok, near, grey, active;
  logic [14:0]   cosv;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign q_push    = in_push && !q_full;

  always_comb begin
    tgt_ok = 1'b1;
    case (target_colour_r)
      TGT_RED:    tgt = HUE_RED;
      TGT_BLUE:   tgt = HUE_BLUE;
      TGT_YELLOW: tgt = HUE_YELLOW;
      default: begin
        tgt    = HUE_RED;
        tgt_ok = 1'b0;
      end
    endcase
    hue_w = (in_item.hue_deg >= HUE_WRAP) ? in_item.hue_deg - HUE_WRAP : in_item.hue_deg;
    diff  = {1'b0, hue_w} + WRAP10 - {1'b0, tgt};
    hue_dist = (diff >= WRAP10) ? 9'(diff - WRAP10) : diff[8:0];
    ang   = (hue_dist <= HUE_HALF) ? hue_dist : HUE_WRAP - hue_dist;
    near  = ang < COS_SPAN;
    cosv  = near ? cos_q15(ang[5:0]) : 15'd0;
    grey  = pair_close(in_item.red_mean, in_item.green_mean)
         && pair_close(in_item.red_mean, in_item.blue_mean)
         && pair_close(in_item.green_mean, in_item.blue_mean);
    active = cnt_r < CW'(MAX_BLOBS);
  end

  always_comb begin
    q_ctl.active  = active;
    q_ctl.qualify = tgt_ok && near && (cosv > MIN_COS) && !grey;
    q_ctl.last    = in_item.last_blob;
    q_cos         = cosv;
    q_sat2        = 16'(in_item.saturation) * 16'(in_item.saturation);
    q_size        = SIZE_BITS'(in_item.pixel_count);
    q_idx         = cnt_r[IW-1:0];
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push) begin
      if (in_item.last_blob) begin
        cnt_nxt = '0;
      end else if (active) begin
        cnt_nxt = cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_colour_r <= TGT_RED;
      cnt_r           <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_valid) begin
        target_colour_r <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/cbbm_queue.sv =====
// Small first-in first-out queue of classified blobs between front and back.
// DEPTH must be a power of two, at least two. No package dependency.
`default_nettype none

module cbbm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [NW-1:0]    count_r;

  assign full  = count_r == NW'(DEPTH);
  assign empty = count_r == '0;
  assign rdata = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + NW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cbbm_back.sv =====
// Back end: forms each blob's score over two multiply steps, keeps the frame's
// largest size and best score, and issues the frame result. Uses cbbm_pkg.
`default_nettype none

module cbbm_back #(
  parameter int SIZE_BITS = 20,
  parameter int IW        = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_empty,
  output logic                      q_pop,
  input  wire cbbm_pkg::cbbm_ctl_t  q_ctl,
  input  wire logic [14:0]          q_cos,
  input  wire logic [15:0]          q_sat2,
  input  wire logic [SIZE_BITS-1:0] q_size,
  input  wire logic [IW-1:0]        q_idx,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output cbbm_pkg::cbbm_out_t       res_item
);
  import cbbm_pkg::*;

  localparam int PW = COS_BITS + SAT2_BITS;
  localparam int SW = PW + SIZE_BITS;
  localparam int TW = SW + 6;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL1 = 5'b00010,
    ST_MUL2 = 5'b00100,
    ST_UPD  = 5'b01000,
    ST_FIN  = 5'b10000
  } back_state_t;

  back_state_t          state_r, state_nxt;
  cbbm_ctl_t            ctl_r;
  logic [14:0]          cos_r;
  logic [15:0]          sat2_r;
  logic [SIZE_BITS-1:0] size_r, largest_r;
  logic [IW-1:0]        idx_r, pos_r;
  logic [PW-1:0]        prod_r;
  logic [SW-1:0]        score_r, best_r;
  logic                 have_r;
  logic [TW-1:0]        lhs, rhs;
  logic                 found;

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ctl_r.last ? ST_FIN : ST_IDLE;
      ST_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // The found test is best * 40 > largest * 2^31; 40 is taken as 32 + 8.
  always_comb begin
    lhs   = (TW'(best_r) << 5) + (TW'(best_r) << 3);
    rhs   = TW'({largest_r, {SCORE_FRAC{1'b0}}});
    found = have_r && (lhs > rhs);
    res_item.found      = found;
    res_item.best_index = found ? 8'(pos_r) : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      have_r    <= 1'b0;
      best_r    <= '0;
      largest_r <= '0;
      pos_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_UPD && ctl_r.active) begin
        if (size_r > largest_r) begin
          largest_r <= size_r;
        end
        if (ctl_r.qualify && (!have_r || score_r > best_r)) begin
          best_r <= score_r;
          pos_r  <= idx_r;
          have_r <= 1'b1;
        end
      end
      if (state_r == ST_FIN && res_ready) begin
        have_r    <= 1'b0;
        best_r    <= '0;
        largest_r <= '0;
        pos_r     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ctl_r  <= q_ctl;
      cos_r  <= q_cos;
      sat2_r <= q_sat2;
      size_r <= q_size;
      idx_r  <= q_idx;
    end
    if (state_r == ST_MUL1) begin
      prod_r <= PW'(cos_r) * PW'(sat2_r);
    end
    if (state_r == ST_MUL2) begin
      score_r <= SW'(prod_r) * SW'(size_r);
    end
  end

endmodule

`default_nettype wire
